FILE: src/sdv_pkg.sv
// Shared types, constants and arithmetic helpers for the sun direction block.
// Depends on nothing; used by sdv_sin and solar_direction_vector.
`default_nettype none
package sdv_pkg;

  localparam int ANGLE_FRACTION_BITS = 16;
  localparam int OUT_FRACTION_BITS   = 15;

  // Q30 values and 32-bit phases (2^32 = one turn)
  typedef logic signed [31:0] q30_t;
  typedef logic [31:0]        phase_t;

  typedef enum logic [1:0] {
    REG_LATITUDE  = 2'd0,
    REG_LONGITUDE = 2'd1,
    REG_DAY       = 2'd2
  } reg_index_t;

  localparam logic signed [23:0] LATITUDE_RESET  = 24'sd2775211;
  localparam logic signed [24:0] LONGITUDE_RESET = -25'sd4659454;
  localparam logic [8:0]         DAY_RESET       = 9'd181;

  // Shift from the input/config angle format to Q30 hours and to phase units
  localparam int HOUR_SHIFT = 30 - ANGLE_FRACTION_BITS;
  localparam int LAT_SHIFT  = 32 - ANGLE_FRACTION_BITS;

  // Q30 constants
  localparam q30_t EOT_SIN1_GAIN = 32'sd182536110;  // 0.170 h
  localparam q30_t EOT_SIN2_GAIN = 32'sd138512695;  // 0.129 h
  localparam q30_t DECL_GAIN     = 32'sd279783318;  // 0.4093 rad in phase units

  // Constant divider: floor(x / d) = (x * K) >> DIV_SHIFT, exact for x < 2^41, d < 512
  localparam int DIV_W     = 41;
  localparam int DIV_KW    = 48;
  localparam int DIV_SHIFT = 50;
  localparam logic [63:0] DIV_ONE = 64'd1 << DIV_SHIFT;
  localparam logic [DIV_KW-1:0] DIV_K_373 = DIV_KW'((DIV_ONE + 64'd372) / 64'd373);
  localparam logic [DIV_KW-1:0] DIV_K_355 = DIV_KW'((DIV_ONE + 64'd354) / 64'd355);
  localparam logic [DIV_KW-1:0] DIV_K_368 = DIV_KW'((DIV_ONE + 64'd367) / 64'd368);
  localparam logic [DIV_KW-1:0] DIV_K_15  = DIV_KW'((DIV_ONE + 64'd14) / 64'd15);
  localparam logic [DIV_KW-1:0] DIV_K_360 = DIV_KW'((DIV_ONE + 64'd359) / 64'd360);
  localparam logic [DIV_KW-1:0] DIV_K_6   = DIV_KW'((DIV_ONE + 64'd5) / 64'd6);

  typedef struct packed {
    logic [44:0] ll;
    logic [44:0] lh;
    logic [43:0] hl;
    logic [43:0] hh;
  } div_pp_t;

  // First half of the reciprocal multiply: four partial products
  function automatic div_pp_t div_pp(input logic [DIV_W-1:0] x, input logic [DIV_KW-1:0] k);
    div_pp_t     d;
    logic [20:0] xl;
    logic [19:0] xh;
    logic [23:0] kl;
    logic [23:0] kh;
    xl = x[20:0];
    xh = x[40:21];
    kl = k[23:0];
    kh = k[47:24];
    d.ll = 45'(xl) * 45'(kl);
    d.lh = 45'(xl) * 45'(kh);
    d.hl = 44'(xh) * 44'(kl);
    d.hh = 44'(xh) * 44'(kh);
    return d;
  endfunction

  // Second half: sum and take the quotient
  function automatic logic [DIV_W-1:0] div_quot(input div_pp_t d);
    logic [90:0] s;
    s = 91'(d.ll) + (91'(d.lh) << 24) + (91'(d.hl) << 21) + (91'(d.hh) << 45);
    return s[DIV_SHIFT +: DIV_W];
  endfunction

  // Q30 product, round to nearest, ties away from zero
  function automatic logic signed [33:0] mulq(input q30_t a, input q30_t b);
    logic signed [63:0] p;
    logic [63:0]        mag;
    logic [63:0]        rm;
    logic [33:0]        r;
    p   = 64'(a) * 64'(b);
    mag = p[63] ? 64'(-p) : 64'(p);
    rm  = (mag + (64'd1 << 29)) >> 30;
    r   = rm[33:0];
    return p[63] ? -$signed(r) : $signed(r);
  endfunction

  localparam int OUT_SHIFT_R = (OUT_FRACTION_BITS < 30) ? 30 - OUT_FRACTION_BITS : 1;
  localparam int OUT_SHIFT_L = (OUT_FRACTION_BITS >= 30) ? OUT_FRACTION_BITS - 30 : 0;

  // Q30 to output format, rounded and saturated, low 16 bits
  function automatic logic [15:0] to_out(input logic signed [33:0] v);
    logic [33:0]        mag;
    logic [39:0]        rm;
    logic signed [39:0] r;
    logic signed [39:0] lim;
    lim = 40'sd1 <<< OUT_FRACTION_BITS;
    mag = v[33] ? 34'(-v) : 34'(v);
    rm  = (40'(mag) + (40'd1 << (OUT_SHIFT_R - 1))) >> OUT_SHIFT_R;
    if (OUT_FRACTION_BITS >= 30) begin
      r = 40'(v) <<< OUT_SHIFT_L;
    end else begin
      r = v[33] ? -$signed(rm) : $signed(rm);
    end
    if (r > lim - 40'sd1) begin
      r = lim - 40'sd1;
    end
    if (r < -lim) begin
      r = -lim;
    end
    return r[15:0];
  endfunction

endpackage
`default_nettype wire

FILE: src/sdv_sin.sv
// Pipelined sine of a 32-bit phase: quadrant fold, then a degree-9 odd polynomial.
// Depends on sdv_pkg. Accepts one phase per cycle.
`default_nettype none
module sdv_sin (
  input  logic           clk,
  input  sdv_pkg::phase_t phase,
  output sdv_pkg::q30_t   value
);

  localparam logic [30:0] C0 = 31'd1686629713;
  localparam logic [30:0] C1 = 31'd693598668;
  localparam logic [30:0] C2 = 31'd85569304;
  localparam logic [30:0] C3 = 31'd5026995;
  localparam logic [30:0] C4 = 31'd172272;
  localparam logic [30:0] QUARTER = 31'd1 << 30;

  // all operands are nonnegative here
  function automatic logic [30:0] rnd(input logic [61:0] p);
    logic [61:0] s;
    s = p + (62'd1 << 29);
    return s[60:30];
  endfunction

  logic [30:0] x1, x2, x3, x4, x5, x6;
  logic        n1, n2, n3, n4, n5, n6;
  logic [30:0] sq2, sq3, sq4, sq5;
  logic [30:0] a3, a2, a1, a0;
  logic [30:0] mag;

  assign mag = rnd(62'(a0) * 62'(x6));

  always_ff @(posedge clk) begin
    x1  <= phase[30] ? QUARTER - 31'(phase[29:0]) : 31'(phase[29:0]);
    n1  <= phase[31];
    x2  <= x1;
    n2  <= n1;
    sq2 <= rnd(62'(x1) * 62'(x1));
    x3  <= x2;
    n3  <= n2;
    sq3 <= sq2;
    a3  <= C3 - rnd(62'(C4) * 62'(sq2));
    x4  <= x3;
    n4  <= n3;
    sq4 <= sq3;
    a2  <= C2 - rnd(62'(a3) * 62'(sq3));
    x5  <= x4;
    n5  <= n4;
    sq5 <= sq4;
    a1  <= C1 - rnd(62'(a2) * 62'(sq4));
    x6  <= x5;
    n6  <= n5;
    a0  <= C0 - rnd(62'(a1) * 62'(sq5));
    value <= n6 ? -sdv_pkg::q30_t'({1'b0, mag}) : sdv_pkg::q30_t'({1'b0, mag});
  end

endmodule
`default_nettype wire

FILE: src/solar_direction_vector.sv
// Top level: sun direction vector from time of day, latitude, longitude and day.
// Depends on sdv_pkg and sdv_sin.
`default_nettype none
// Channel      Signals                         Direction  Handshake
// command      start, busy, hour_of_day        in         start & !busy
// result       done, dir_x, dir_y, dir_z       out        done, one cycle
// config       wr_en, wr_index, wr_data        in         wr_en
//
// One word accepted every cycle; busy is never raised. Depth is set by two chained
// sine pipelines, two constant dividers on that path (day phase: partial products,
// then quotient; hour angle: partial products, quotient, then its sign restore) and
// the product/sum tail.
// rst (synchronous) clears the valid line and loads the register defaults.
// The result side cannot stall, so the pipeline never holds.
module solar_direction_vector (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [20:0]        hour_of_day,
  input  logic               wr_en,
  input  logic [1:0]         wr_index,
  input  logic [24:0]        wr_data,
  output logic               done,
  output logic signed [15:0] dir_x,
  output logic signed [15:0] dir_y,
  output logic signed [15:0] dir_z
);

  localparam int LAST = 25;

  // configuration registers
  logic signed [23:0] latitude_deg;
  logic signed [24:0] longitude_deg;
  logic [8:0]         day_number;

  always_ff @(posedge clk) begin
    if (rst) begin
      latitude_deg  <= sdv_pkg::LATITUDE_RESET;
      longitude_deg <= sdv_pkg::LONGITUDE_RESET;
      day_number    <= sdv_pkg::DAY_RESET;
    end else if (wr_en) begin
      case (sdv_pkg::reg_index_t'(wr_index))
        sdv_pkg::REG_LATITUDE:  latitude_deg  <= wr_data[23:0];
        sdv_pkg::REG_LONGITUDE: longitude_deg <= wr_data;
        sdv_pkg::REG_DAY:       day_number    <= wr_data[8:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // valid line, one bit per stage
  logic [LAST:0] vld;
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAST-1:0], start & ~busy};
    end
  end
  assign done = vld[LAST];

  // stage 0: capture
  logic [20:0]        hour_d [12];
  logic signed [23:0] lat0;
  logic signed [24:0] lon0;
  logic [8:0]         day0;

  always_ff @(posedge clk) begin
    hour_d[0] <= hour_of_day;
    for (int i = 1; i < 12; i++) begin
      hour_d[i] <= hour_d[i-1];
    end
    lat0 <= latitude_deg;
    lon0 <= longitude_deg;
    day0 <= day_number;
  end

  // stage 1: day terms reduced into their periods; |angle| + half divisor
  logic [10:0] ea1;
  logic [9:0]  ea2, ea3;
  logic [8:0]  m1_n, m2_n, m3_n;
  logic [24:0] lon_mag;
  logic [23:0] lat_mag;
  logic [8:0]  m1, m2, m3;
  logic [sdv_pkg::DIV_W-1:0] lonx1, latx1;
  logic lonn1, latn1;

  always_comb begin
    ea1 = 11'({day0, 1'b0}) + 11'd213;  // 2*(d-80) + 373
    ea2 = 10'(day0) + 10'd347;          // (d-8) + 355
    ea3 = 10'(day0) + 10'd287;          // (d-81) + 368
    if (ea1 >= 11'd1119)     m1_n = 9'(ea1 - 11'd1119);
    else if (ea1 >= 11'd746) m1_n = 9'(ea1 - 11'd746);
    else if (ea1 >= 11'd373) m1_n = 9'(ea1 - 11'd373);
    else                     m1_n = 9'(ea1);
    if (ea2 >= 10'd710)      m2_n = 9'(ea2 - 10'd710);
    else if (ea2 >= 10'd355) m2_n = 9'(ea2 - 10'd355);
    else                     m2_n = 9'(ea2);
    if (ea3 >= 10'd736)      m3_n = 9'(ea3 - 10'd736);
    else if (ea3 >= 10'd368) m3_n = 9'(ea3 - 10'd368);
    else                     m3_n = 9'(ea3);
    lon_mag = lon0[24] ? 25'(-lon0) : 25'(lon0);
    lat_mag = lat0[23] ? 24'(-lat0) : 24'(lat0);
  end

  always_ff @(posedge clk) begin
    m1    <= m1_n;
    m2    <= m2_n;
    m3    <= m3_n;
    lonx1 <= (41'(lon_mag) << sdv_pkg::HOUR_SHIFT) + 41'd7;
    lonn1 <= lon0[24];
    latx1 <= (41'(lat_mag) << sdv_pkg::LAT_SHIFT) + 41'd180;
    latn1 <= lat0[23];
  end

  // stages 2-3: constant dividers (day phases, longitude/15, latitude/360)
  sdv_pkg::div_pp_t pp_e1, pp_e2, pp_dc, pp_lon, pp_lat;
  logic lonn2, latn2, lonn3, latn3;
  sdv_pkg::phase_t ph_e1, ph_e2, ph_dc;
  logic [sdv_pkg::DIV_W-1:0] lonq3, latq3;
  logic [sdv_pkg::DIV_W-1:0] qe1, qe2, qdc;

  always_ff @(posedge clk) begin
    pp_e1  <= sdv_pkg::div_pp(41'({m1, 32'd0}), sdv_pkg::DIV_K_373);
    pp_e2  <= sdv_pkg::div_pp(41'({m2, 32'd0}), sdv_pkg::DIV_K_355);
    pp_dc  <= sdv_pkg::div_pp(41'({m3, 32'd0}), sdv_pkg::DIV_K_368);
    pp_lon <= sdv_pkg::div_pp(lonx1, sdv_pkg::DIV_K_15);
    pp_lat <= sdv_pkg::div_pp(latx1, sdv_pkg::DIV_K_360);
    lonn2  <= lonn1;
    latn2  <= latn1;
    lonq3  <= sdv_pkg::div_quot(pp_lon);
    latq3  <= sdv_pkg::div_quot(pp_lat);
    lonn3  <= lonn2;
    latn3  <= latn2;
  end

  assign qe1 = sdv_pkg::div_quot(pp_e1);
  assign qe2 = sdv_pkg::div_quot(pp_e2);
  assign qdc = sdv_pkg::div_quot(pp_dc);

  always_ff @(posedge clk) begin
    ph_e1 <= qe1[31:0];
    ph_e2 <= qe2[31:0];
    ph_dc <= qdc[31:0];
  end

  // stage 4: signed fractional part of longitude/15 (ties to even hour), latitude phase
  logic [sdv_pkg::DIV_W-1:0] lu;
  logic signed [30:0] fr_n;
  logic signed [30:0] fr_d [4:11];
  sdv_pkg::phase_t    lp4;

  always_comb begin
    lu = lonn3 ? (41'd0 - lonq3) : lonq3;
    if (lu[29:0] > 30'h2000_0000 || (lu[29:0] == 30'h2000_0000 && lu[30])) begin
      fr_n = $signed({1'b0, lu[29:0]}) - 31'sh4000_0000;
    end else begin
      fr_n = $signed({1'b0, lu[29:0]});
    end
  end

  always_ff @(posedge clk) begin
    fr_d[4] <= fr_n;
    for (int i = 5; i < 12; i++) begin
      fr_d[i] <= fr_d[i-1];
    end
    lp4 <= latn3 ? (32'd0 - latq3[31:0]) : latq3[31:0];
  end

  // stages 4-10: equation-of-time and declination sines; 5-11: latitude sin/cos
  sdv_pkg::q30_t se1, se2, sdc, sl11, cl11;

  sdv_sin u_sin_e1 (.clk(clk), .phase(ph_e1), .value(se1));
  sdv_sin u_sin_e2 (.clk(clk), .phase(ph_e2), .value(se2));
  sdv_sin u_sin_dc (.clk(clk), .phase(ph_dc), .value(sdc));
  sdv_sin u_sin_lat (.clk(clk), .phase(lp4), .value(sl11));
  sdv_sin u_cos_lat (.clk(clk), .phase(lp4 + 32'h4000_0000), .value(cl11));

  // stage 11: scaled equation of time and declination phase
  logic signed [33:0] eot1, eot2, dprod;
  sdv_pkg::phase_t    dp11;

  assign dprod = sdv_pkg::mulq(sdv_pkg::DECL_GAIN, sdc);

  always_ff @(posedge clk) begin
    eot1 <= sdv_pkg::mulq(sdv_pkg::EOT_SIN1_GAIN, se1);
    eot2 <= sdv_pkg::mulq(sdv_pkg::EOT_SIN2_GAIN, se2);
    dp11 <= dprod[31:0];
  end

  // stage 12: solar time, |solar| + 3 for rounding /6
  logic signed [37:0] hq, solar;
  logic [37:0]        solar_mag;
  logic [sdv_pkg::DIV_W-1:0] sx12;
  logic sneg12, sneg13, sneg14;

  always_comb begin
    hq        = $signed(38'(hour_d[11]) << sdv_pkg::HOUR_SHIFT);
    solar     = hq + 38'(eot1) - 38'(eot2) + 38'(fr_d[11]);
    solar_mag = solar[37] ? 38'(-solar) : 38'(solar);
  end

  always_ff @(posedge clk) begin
    sx12   <= 41'(solar_mag) + 41'd3;
    sneg12 <= solar[37];
  end

  // stages 12-18: declination sin/cos
  sdv_pkg::q30_t sd18, cd18;
  sdv_sin u_sin_dec (.clk(clk), .phase(dp11), .value(sd18));
  sdv_sin u_cos_dec (.clk(clk), .phase(dp11 + 32'h4000_0000), .value(cd18));

  // stages 13-15: hour angle phase = solar / 6
  sdv_pkg::div_pp_t pp_h;
  logic [sdv_pkg::DIV_W-1:0] qh14;
  sdv_pkg::phase_t hp15;

  always_ff @(posedge clk) begin
    pp_h   <= sdv_pkg::div_pp(sx12, sdv_pkg::DIV_K_6);
    sneg13 <= sneg12;
    qh14   <= sdv_pkg::div_quot(pp_h);
    sneg14 <= sneg13;
    hp15   <= sneg14 ? (32'd0 - qh14[31:0]) : qh14[31:0];
  end

  // stages 16-22: hour angle sin/cos
  sdv_pkg::q30_t sh22, ch22;
  sdv_sin u_sin_h (.clk(clk), .phase(hp15), .value(sh22));
  sdv_sin u_cos_h (.clk(clk), .phase(hp15 + 32'h4000_0000), .value(ch22));

  // alignment delays
  sdv_pkg::q30_t sd_d [19:22];
  sdv_pkg::q30_t cd_d [19:22];
  sdv_pkg::q30_t sl_d [12:23];
  sdv_pkg::q30_t cl_d [12:23];

  always_ff @(posedge clk) begin
    sd_d[19] <= sd18;
    cd_d[19] <= cd18;
    for (int i = 20; i < 23; i++) begin
      sd_d[i] <= sd_d[i-1];
      cd_d[i] <= cd_d[i-1];
    end
    sl_d[12] <= sl11;
    cl_d[12] <= cl11;
    for (int i = 13; i < 24; i++) begin
      sl_d[i] <= sl_d[i-1];
      cl_d[i] <= cl_d[i-1];
    end
  end

  // stage 23: first products
  logic signed [33:0] cdch23, x23, clsd23, slsd23;
  // stage 24: second products
  logic signed [33:0] slc24, clc24, x24, clsd24, slsd24;

  always_ff @(posedge clk) begin
    cdch23 <= sdv_pkg::mulq(cd_d[22], ch22);
    x23    <= sdv_pkg::mulq(cd_d[22], sh22);
    clsd23 <= sdv_pkg::mulq(cl_d[22], sd_d[22]);
    slsd23 <= sdv_pkg::mulq(sl_d[22], sd_d[22]);
    slc24  <= sdv_pkg::mulq(sl_d[23], sdv_pkg::q30_t'(cdch23[31:0]));
    clc24  <= sdv_pkg::mulq(cl_d[23], sdv_pkg::q30_t'(cdch23[31:0]));
    x24    <= x23;
    clsd24 <= clsd23;
    slsd24 <= slsd23;
  end

  // stage 25: sums, rounding to the output format, saturation
  always_ff @(posedge clk) begin
    dir_x <= sdv_pkg::to_out(x24);
    dir_y <= sdv_pkg::to_out(clsd24 + slc24);
    dir_z <= sdv_pkg::to_out(slsd24 - clc24);
  end

endmodule
`default_nettype wire
